// ----- hw/rtl/arcv_pkg.sv -----
package arcv_pkg;

   // Field widths
   localparam int VoltW  = 12;
   localparam int LimW   = 17;
   localparam int ShiftW = 4;
   localparam int IdxW   = 3;
   localparam int GainW  = 6;
   localparam int ErrW   = 15;
   localparam int IntegW = 18;
   localparam int SumW   = 22;
   localparam int ReqDataW = 40;
   localparam int RspDataW = 40;

   typedef logic signed [LimW-1:0] lim_type;

   // Configuration register file contents
   typedef struct packed {
      logic              mig_mode;
      logic              twin_pulse_mode;
      logic              alu_gain_set;
      lim_type           limit_high;
      lim_type           limit_low;
      logic [ShiftW-1:0] pulse_shift;
      logic [ShiftW-1:0] mig_shift;
   } cfg_type;

   // Input item, last field in the lowest bits
   typedef struct packed {
      logic             weld_detected;
      logic             load_volt_flag;
      logic             twin_high_phase;
      logic [VoltW-1:0] twin_offset;
      logic [VoltW-1:0] setpoint_voltage;
      logic [VoltW-1:0] feedback_voltage;
   } req_item_type;

   // Register indexes on the configuration port
   localparam logic [IdxW-1:0] REG_MIG_MODE        = 3'd0;
   localparam logic [IdxW-1:0] REG_TWIN_PULSE_MODE = 3'd1;
   localparam logic [IdxW-1:0] REG_ALU_GAIN_SET    = 3'd2;
   localparam logic [IdxW-1:0] REG_LIMIT_HIGH      = 3'd3;
   localparam logic [IdxW-1:0] REG_LIMIT_LOW       = 3'd4;
   localparam logic [IdxW-1:0] REG_PULSE_SHIFT     = 3'd5;
   localparam logic [IdxW-1:0] REG_MIG_SHIFT       = 3'd6;

   // Fixed limits and drive values
   localparam lim_type LIMIT_HIGH_RESET = 17'sd64000;
   localparam lim_type MIG_UPPER_LIMIT  = 17'sd64000;
   localparam lim_type MIG_OUT_CAP      = 17'sd800;
   localparam lim_type MIG_IDLE_DRIVE   = 17'sd200;

   // Gains
   localparam logic [GainW-1:0] KP_STD = 6'd42;
   localparam logic [GainW-1:0] KI_STD = 6'd2;
   localparam logic [GainW-1:0] KP_ALT = 6'd28;
   localparam logic [GainW-1:0] KI_ALT = 6'd4;
   localparam logic [GainW-1:0] KD     = 6'd20;

endpackage

// ----- hw/rtl/arcv_cfg_regs.sv -----
module arcv_cfg_regs
   import arcv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IdxW-1:0]     csr_index,
   input  logic [LimW-1:0]     csr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MIG_MODE:        cfg_in.mig_mode        = csr_data[0];
            REG_TWIN_PULSE_MODE: cfg_in.twin_pulse_mode = csr_data[0];
            REG_ALU_GAIN_SET:    cfg_in.alu_gain_set    = csr_data[0];
            REG_LIMIT_HIGH:      cfg_in.limit_high      = lim_type'(csr_data);
            REG_LIMIT_LOW:       cfg_in.limit_low       = lim_type'(csr_data);
            REG_PULSE_SHIFT:     cfg_in.pulse_shift     = csr_data[ShiftW-1:0];
            REG_MIG_SHIFT:       cfg_in.mig_shift       = csr_data[ShiftW-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mig_mode        <= 1'b0;
         cfg_ff.twin_pulse_mode <= 1'b0;
         cfg_ff.alu_gain_set    <= 1'b0;
         cfg_ff.limit_high      <= LIMIT_HIGH_RESET;
         cfg_ff.limit_low       <= '0;
         cfg_ff.pulse_shift     <= '0;
         cfg_ff.mig_shift       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/arcv_in_reg.sv -----
module arcv_in_reg
   import arcv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                take,
   output logic                item_valid,
   output req_item_type        item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // Accept while empty or while the held item moves on
   assign req_tready = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on each transaction
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
      end
   end

endmodule

// ----- hw/rtl/arcv_pid_core.sv -----
module arcv_pid_core
   import arcv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                item_valid,
   input  req_item_type        item,
   output logic                take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata
);

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RspDataW-1:0]      rsp_data_ff;
   logic signed [IntegW-1:0] integ_ff;
   logic signed [ErrW-1:0]   last_err_ff;

   logic signed [13:0]       sp_base;
   logic signed [13:0]       sp_ofs;
   logic signed [13:0]       sp;
   logic signed [ErrW-1:0]   err;
   logic signed [ErrW:0]     err_diff;
   lim_type                  hi;
   logic [ShiftW-1:0]        sh;
   logic [GainW-1:0]         kp;
   logic [GainW-1:0]         ki;
   logic signed [SumW-1:0]   acc_raw;
   lim_type                  acc;
   logic signed [SumW-1:0]   p_term;
   logic signed [SumW-1:0]   i_term;
   logic signed [SumW-1:0]   d_term;
   logic signed [SumW-1:0]   sum;
   lim_type                  sum_c;
   lim_type                  shifted;
   lim_type                  res;
   lim_type                  drive;

   // Upper test first, then lower
   function automatic lim_type clamp17(input logic signed [SumW-1:0] v,
                                      input lim_type hi_lim,
                                      input lim_type lo_lim);
      lim_type r;
      if (v >= SumW'(hi_lim)) begin
         r = hi_lim;
      end else if (v <= SumW'(lo_lim)) begin
         r = lo_lim;
      end else begin
         r = v[LimW-1:0];
      end
      return r;
   endfunction

   assign take       = item_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Pick mode-dependent upper limit, shift and gains
   always_comb begin
      kp = KP_STD;
      ki = KI_STD;
      if (cfg.mig_mode) begin
         hi = MIG_UPPER_LIMIT;
         sh = cfg.mig_shift;
         if (cfg.alu_gain_set) begin
            kp = KP_ALT;
            ki = KI_ALT;
         end
      end else begin
         hi = cfg.limit_high;
         sh = cfg.pulse_shift;
      end
   end

   // Setpoint with optional twin offset in pulse mode
   always_comb begin
      sp_base = signed'({2'b00, item.setpoint_voltage});
      sp_ofs  = signed'({2'b00, item.twin_offset});
      sp      = sp_base;
      if (!cfg.mig_mode && cfg.twin_pulse_mode && item.load_volt_flag) begin
         sp = item.twin_high_phase ? sp_base + sp_ofs : sp_base - sp_ofs;
      end
   end

   assign err      = ErrW'(sp) - signed'({3'b000, item.feedback_voltage});
   assign err_diff = (ErrW+1)'(err) - (ErrW+1)'(last_err_ff);

   // Integrate and clamp
   assign acc_raw = SumW'(integ_ff) + SumW'(err);
   assign acc     = clamp17(acc_raw, hi, cfg.limit_low);

   // PID terms and output shaping
   assign p_term = SumW'(err) * signed'({1'b0, kp});
   assign i_term = SumW'(acc) * signed'({1'b0, ki});
   assign d_term = SumW'(err_diff) * signed'({1'b0, KD});
   assign sum    = p_term + i_term + d_term;
   assign sum_c  = clamp17(sum, hi, cfg.limit_low);
   assign shifted = sum_c >>> sh;

   always_comb begin
      res   = shifted;
      drive = '0;
      if (cfg.mig_mode) begin
         if (shifted >= MIG_OUT_CAP) begin
            res = MIG_OUT_CAP;
         end
         drive = item.weld_detected ? res : MIG_IDLE_DRIVE;
      end
   end

   // Hold the result until taken; load a new one on advance
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            integ_ff    <= IntegW'(acc);
            last_err_ff <= err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= {{(RspDataW - 2*LimW){1'b0}}, drive, res};
      end
   end

endmodule

// ----- hw/rtl/arc_voltage_pid_regulator.sv -----
// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | req_tdata: voltage sample and flags
// rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: control_out, mig_drive
// csr     | in        | csr_valid/csr_ready    | csr_index, csr_data (always ready)
//
// Each sample is held in the input register and passes through the PID
// arithmetic before its result lands in the output register; one sample per
// cycle sustained while the rsp side is ready.
// Reset (synchronous) clears the integrator, the last error, the valid flags and the config registers.
// A stalled rsp side holds the result; req keeps accepting while a slot is free.
module arc_voltage_pid_regulator
   import arcv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [11:0] feedback_voltage, [23:12] setpoint_voltage, [35:24] twin_offset,
   // [36] twin_high_phase, [37] load_volt_flag, [38] weld_detected, [39] zero
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [16:0] control_out, [33:17] mig_drive, [39:34] zero
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IdxW-1:0]     csr_index,
   input  logic [LimW-1:0]     csr_data
);

   cfg_type      cfg;
   req_item_type item;
   logic         item_valid;
   logic         take;

   arcv_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   arcv_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   arcv_pid_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
